>>> design/sscrc_pkg.sv
// Types, constants and the CRC byte step shared by the seeded CRC-16 unit.
`timescale 1ns / 1ps
`default_nettype none
package sscrc_pkg;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'h1021;
  localparam int          BYTE_BITS         = 8;
  localparam int          SIG_W             = 64;
  localparam int          SIG_BYTES_MAX     = 8;
  localparam int          SIG_BYTES_DEFAULT = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic        crc_final;
  } out_word_t;

  // One byte through the CRC, MSB first, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    r = crc ^ {data, 8'h00};
    for (int k = 0; k < BYTE_BITS; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/sscrc_seed.sv
// Seed engine: absorbs the signature bytes, one per cycle, after reset or a write.
`timescale 1ns / 1ps
`default_nettype none
module sscrc_seed #(
  parameter int SIG_BYTE_COUNT = sscrc_pkg::SIG_BYTES_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [sscrc_pkg::SIG_W-1:0] cfg_wr_data,
  output logic [15:0]                     seed,
  output logic                            busy
);
  import sscrc_pkg::*;

  localparam int NBytes = (SIG_BYTE_COUNT > SIG_BYTES_MAX) ? SIG_BYTES_MAX :
                          (SIG_BYTE_COUNT < 0) ? 0 : SIG_BYTE_COUNT;
  localparam int CntW   = (NBytes > 0) ? $clog2(NBytes + 1) : 1;

  logic [SIG_W-1:0] sig_shift;
  logic [CntW-1:0]  cnt;

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= CntW'(NBytes);
      seed      <= CRC_INIT;
      sig_shift <= '0;
    end else if (cfg_wr_en) begin
      cnt       <= CntW'(NBytes);
      seed      <= CRC_INIT;
      sig_shift <= cfg_wr_data;
    end else if (busy) begin
      cnt       <= cnt - CntW'(1);
      seed      <= crc_byte(seed, sig_shift[7:0]);
      sig_shift <= {8'h00, sig_shift[SIG_W-1:8]};
    end
  end

  a_cnt_down: assert property (@(posedge clk) disable iff (rst)
    busy && !cfg_wr_en |=> cnt == $past(cnt) - CntW'(1))
    else $error("seed counter did not step");

endmodule
`default_nettype wire

>>> design/sscrc_core.sv
// Running CRC: picks seed or running value and absorbs one payload byte.
`timescale 1ns / 1ps
`default_nettype none
module sscrc_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire sscrc_pkg::in_word_t in_data,
  input  wire logic [15:0]         seed,
  output sscrc_pkg::out_word_t     result
);
  import sscrc_pkg::*;

  logic [15:0] running_crc;
  logic        start_pending;
  logic [15:0] crc_next;

  assign crc_next = crc_byte(start_pending ? seed : running_crc, in_data.data_byte);
  assign result   = '{crc_value: crc_next, crc_final: in_data.last_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= CRC_INIT;
      start_pending <= 1'b1;
    end else if (accept) begin
      running_crc   <= crc_next;
      start_pending <= in_data.last_byte;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> start_pending == $past(in_data.last_byte))
    else $error("start flag does not follow last byte");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(running_crc) && $stable(start_pending))
    else $error("running crc moved without a word");

endmodule
`default_nettype wire

>>> design/sscrc_skid.sv
// Output register with a skid stage so a word can be taken while one waits.
`timescale 1ns / 1ps
`default_nettype none
module sscrc_skid (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire sscrc_pkg::out_word_t result,
  output logic                      full,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output sscrc_pkg::out_word_t      out_data
);
  import sscrc_pkg::*;

  out_word_t skid;
  logic      skid_valid;

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_data   <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && out_stall) begin
        skid       <= result;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result;
        out_valid <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word ahead of an empty output");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    accept |-> !skid_valid)
    else $error("word taken while skid is full");

endmodule
`default_nettype wire

>>> design/signature_seeded_crc16_unit.sv
// Top level of the signature-seeded CRC-16 unit.
`timescale 1ns / 1ps
`default_nettype none
// CRC-16 (poly 0x1021, MSB first, init 0xFFFF, no final xor) over payload bytes,
// one byte per word, one result word per input word with the running CRC. Each
// transfer starts from a seed: the CRC of the low SIG_BYTE_COUNT bytes of the
// signature register, low byte first. The unit takes one word every cycle while
// in_stall is low; a result waiting under out_stall does not block the next
// word thanks to a skid stage. After reset and after every cfg_wr_en the seed
// engine absorbs one signature byte per cycle, holding in_stall high until
// all SIG_BYTE_COUNT (8 by default) are in; a write applies to the next transfer.
module signature_seeded_crc16_unit #(
  parameter int SIG_BYTE_COUNT = sscrc_pkg::SIG_BYTES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire sscrc_pkg::in_word_t         in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output sscrc_pkg::out_word_t             out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [sscrc_pkg::SIG_W-1:0] cfg_wr_data
);
  import sscrc_pkg::*;

  logic [15:0] seed;
  logic        seed_busy;
  logic        skid_full;
  logic        accept;
  out_word_t   result;

  assign in_stall = seed_busy | skid_full;
  assign accept   = in_valid & ~in_stall;

  sscrc_seed #(
    .SIG_BYTE_COUNT(SIG_BYTE_COUNT)
  ) u_seed (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .seed       (seed),
    .busy       (seed_busy)
  );

  sscrc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .in_data(in_data),
    .seed   (seed),
    .result (result)
  );

  sscrc_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .result   (result),
    .full     (skid_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> tb/tb_signature_seeded_crc16_unit.sv
// Self-checking testbench for the signature-seeded CRC-16 unit.
`timescale 1ns / 1ps
module tb_signature_seeded_crc16_unit;
  import sscrc_pkg::*;

  localparam int SIG_BYTES    = SIG_BYTES_DEFAULT;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 100;
  localparam int HOLD_PHASE   = 3;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_WORDS   = 40;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_DIR      = 19;

  typedef enum logic {ROW_WORD, ROW_SIG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [63:0] value;  // data byte, or the signature for ROW_SIG
    logic        last;
    logic        typed;  // crc below is the expected value
    logic [15:0] crc;
  } stim_row_t;

  // Signature 0x..FFFF drives the seed to zero, so the CRCs after it are plain
  // table entries. The all-ones write lands mid-transfer on purpose.
  localparam stim_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_WORD, 64'h00, 1'b0, 1'b0, 16'h0000},
    '{ROW_WORD, 64'hFF, 1'b1, 1'b0, 16'h0000},
    '{ROW_WORD, 64'hA5, 1'b1, 1'b0, 16'h0000},
    '{ROW_SIG,  64'h0000_0000_0000_FFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_WORD, 64'h00, 1'b0, 1'b1, 16'h0000},
    '{ROW_WORD, 64'h00, 1'b1, 1'b1, 16'h0000},
    '{ROW_WORD, 64'h01, 1'b1, 1'b1, 16'h1021},
    '{ROW_WORD, 64'h80, 1'b1, 1'b1, 16'h9188},
    '{ROW_WORD, 64'h3C, 1'b0, 1'b0, 16'h0000},
    '{ROW_SIG,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_WORD, 64'h5A, 1'b1, 1'b0, 16'h0000},
    '{ROW_WORD, 64'hFF, 1'b1, 1'b0, 16'h0000},
    '{ROW_SIG,  64'h8000_0000_0000_0001, 1'b0, 1'b0, 16'h0000},
    '{ROW_WORD, 64'h7F, 1'b0, 1'b0, 16'h0000},
    '{ROW_WORD, 64'hFE, 1'b1, 1'b0, 16'h0000},
    '{ROW_SIG,  64'h0, 1'b0, 1'b0, 16'h0000},
    '{ROW_WORD, 64'h00, 1'b1, 1'b0, 16'h0000},
    '{ROW_SIG,  64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 16'h0000},
    '{ROW_WORD, 64'hC3, 1'b1, 1'b0, 16'h0000}
  };

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  in_word_t         in_data     = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  out_word_t        out_data;
  logic             cfg_wr_en   = 1'b0;
  logic [SIG_W-1:0] cfg_wr_data = '0;

  // predictor state
  logic [15:0]      pred_running;
  logic [15:0]      pred_seed;
  bit               pred_open;

  out_word_t pending_crcs[$];
  out_word_t mon_want;
  int        fail_count;
  int        words_checked;
  int        transfers_closed;
  int        signature_writes;
  int        cycle_count;
  bit        hold_req;
  int        snd_left;
  bit        snd_calm;

  signature_seeded_crc16_unit #(
    .SIG_BYTE_COUNT(SIG_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit-serial form: feedback is the register MSB xor the incoming data bit
  function automatic logic [15:0] crc16_absorb(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic logic [15:0] seed_of(input logic [SIG_W-1:0] s);
    logic [15:0] c;
    int          n;
    c = CRC_INIT;
    n = (SIG_BYTES > SIG_BYTES_MAX) ? SIG_BYTES_MAX : SIG_BYTES;
    for (int k = 0; k < n; k++) begin
      c = crc16_absorb(c, s[8*k +: 8]);
    end
    return c;
  endfunction

  function automatic out_word_t next_running_crc(input in_word_t w);
    out_word_t r;
    if (pred_open) begin
      pred_running = pred_seed;
    end
    pred_running = crc16_absorb(pred_running, w.data_byte);
    pred_open    = w.last_byte;
    r.crc_value  = pred_running;
    r.crc_final  = w.last_byte;
    return r;
  endfunction

  // idle cycles per word; stretches of 20..60 words are either calm or busy
  function automatic int pick_idle(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(20, 60);
      calm = ($urandom_range(0, 2) == 0);
    end
    left--;
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input logic [15:0] typed_crc);
    out_word_t want;
    int        gap;
    gap = pick_idle(snd_left, snd_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    want = next_running_crc(w);
    if (typed) begin
      want.crc_value = typed_crc;
    end
    pending_crcs.push_back(want);
  endtask

  // only written once every result is back; may fall mid-transfer
  task automatic write_signature(input logic [SIG_W-1:0] s);
    in_valid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pred_seed = seed_of(s);
    signature_writes++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_crcs.size() == 0) begin
        $error("result word with none expected: crc_value=%h crc_final=%b",
               out_data.crc_value, out_data.crc_final);
        fail_count++;
      end else begin
        mon_want = pending_crcs.pop_front();
        words_checked++;
        if (out_data.crc_final === 1'b1) begin
          transfers_closed++;
        end
        if (out_data.crc_value !== mon_want.crc_value) begin
          $error("crc_value: expected %h, got %h", mon_want.crc_value, out_data.crc_value);
          fail_count++;
        end
        if (out_data.crc_final !== mon_want.crc_final) begin
          $error("crc_final: expected %b, got %b", mon_want.crc_final, out_data.crc_final);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stall before each word, one long hold-off on request
  initial begin
    int n;
    int left;
    bit calm;
    left = 0;
    calm = 1'b0;
    wait (!rst);
    forever begin
      if (hold_req) begin
        n        = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = pick_idle(left, calm);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           pending_crcs.size());
    $display("signature_seeded_crc16_unit test failed");
    $finish;
  end

  initial begin
    in_word_t         w;
    int               remaining;
    logic [SIG_W-1:0] s;
    fail_count       = 0;
    words_checked    = 0;
    transfers_closed = 0;
    signature_writes = 0;
    hold_req         = 1'b0;
    snd_left         = 0;
    snd_calm         = 1'b0;
    pred_running     = CRC_INIT;
    pred_seed        = seed_of('0);
    pred_open        = 1'b1;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_SIG) begin
        write_signature(DIR_ROWS[i].value);
      end else begin
        w.data_byte = DIR_ROWS[i].value[7:0];
        w.last_byte = DIR_ROWS[i].last;
        send_word(w, DIR_ROWS[i].typed, DIR_ROWS[i].crc);
      end
    end

    remaining = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p > 0) begin
        case ($urandom_range(0, 4))
          0:       s = '0;
          1:       s = '1;
          2:       s = 64'h1 << $urandom_range(0, 63);
          default: s = {$urandom, $urandom};
        endcase
        write_signature(s);
      end
      if (p == HOLD_PHASE) begin
        // back-to-back words against a stalled output fill the skid stage
        hold_req = 1'b1;
        snd_left = HOLD_WORDS;
        snd_calm = 1'b1;
      end
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (remaining == 0) begin
          case ($urandom_range(0, 9))
            0:       remaining = 1;
            1:       remaining = $urandom_range(17, 64);
            default: remaining = $urandom_range(2, 16);
          endcase
        end
        w.data_byte = 8'($urandom_range(0, 255));
        w.last_byte = (remaining == 1);
        remaining--;
        send_word(w, 1'b0, 16'h0000);
      end
    end

    in_valid <= 1'b0;
    while (pending_crcs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d CRC words over %0d closed transfers and %0d signature writes,",
             words_checked, transfers_closed, signature_writes);
    $display("including writes between transfers and mid-transfer, and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("signature_seeded_crc16_unit test passed");
    end else begin
      $display("signature_seeded_crc16_unit test failed");
    end
    $finish;
  end

endmodule
